[sv/htwd_pkg.sv]
// Package for the tree-walk decoder: field widths, the node entry layout,
// request codes and the controller state type. No dependencies.
package htwd_pkg;

	localparam int NODE_COUNT_DEF = 512;
	localparam int IDX_W          = 9;
	localparam int SYM_W          = 8;
	localparam int BYTE_W         = 8;
	localparam int CNT_W          = 4;
	localparam int MAX_BITS       = 8;
	localparam int ENTRY_W        = 2 * IDX_W + SYM_W;

	localparam logic REQ_NODE_WRITE = 1'b0;
	localparam logic REQ_DECODE     = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [SYM_W-1:0] sym;
	} node_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} walk_state_t;

endpackage

[sv/htwd_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module htwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[sv/huffman_tree_walk_decoder.sv]
// Huffman tree-walk decoder top level: node table in a RAM and the bit walk.
// Depends on htwd_pkg and htwd_ram.
//
// Usage: an item is accepted on a rising edge with start high and busy low.
// With req_type at the node-write code the item loads one node table entry
// (left child, right child, symbol) on that same edge; busy stays low, so
// node writes can be issued back to back. An index at or past NODE_COUNT is
// dropped. With req_type at the decode code the item brings data_byte and
// bit_count (values above 8 count as 8); bits are consumed MSB first.
// The walk is bit serial: the byte sits in a shift register and each coded
// bit costs one dependent read of the node table RAM, so one cycle per bit
// outside leaf steps: a child that turns out to be a leaf costs an extra
// step, in which no bit is consumed, to emit its symbol. A decode item keeps
// busy high through the walk and the flush state after it, and the next item
// is accepted only once busy has fallen; items are not overlapped.
// Results are shown for one cycle with result_strobe high and cannot be held
// off; they trail the walk, since each result waits in the pending register
// until it is known whether it is the last of its byte. The last
// result of a byte carries last_of_run and is shown in the cycle busy falls.
// A missing child gives a result with walk_error set and symbol zero and
// sends the walk back to the root. Reset returns the walk to the root and
// drops any pending result; the node table contents are undefined until
// written, and no clearing pass is made.
module huffman_tree_walk_decoder #(
	parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      req_type,
	input  logic [htwd_pkg::IDX_W-1:0]  node_index,
	input  logic [htwd_pkg::IDX_W-1:0]  left_child,
	input  logic [htwd_pkg::IDX_W-1:0]  right_child,
	input  logic [htwd_pkg::SYM_W-1:0]  node_symbol,
	input  logic [htwd_pkg::BYTE_W-1:0] data_byte,
	input  logic [htwd_pkg::CNT_W-1:0]  bit_count,
	input  logic                      final_byte,
	output logic                      result_strobe,
	output logic [htwd_pkg::SYM_W-1:0]  symbol,
	output logic                      walk_error,
	output logic                      last_of_run
);

	import htwd_pkg::*;

	localparam int AW = $clog2(NODE_COUNT);

	// Controller state and walk registers.
	walk_state_t       state_q, state_d;
	logic [AW-1:0]     pos_q;
	logic [BYTE_W-1:0] bits_q;
	logic [CNT_W-1:0]  left_q;
	logic              fin_q;
	logic              use_root_q;
	logic              chk_q;
	node_entry_t       root_q;

	// Result waiting for its last_of_run decision.
	logic              pend_v_q;
	logic [SYM_W-1:0]  pend_sym_q;
	logic              pend_err_q;

	// Output registers.
	logic              res_strobe_q;
	logic [SYM_W-1:0]  res_sym_q;
	logic              res_err_q;
	logic              res_last_q;

	// RAM signals.
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	// Walk datapath.
	node_entry_t       ent;
	logic              is_leaf;
	logic              cur_bit;
	logic [IDX_W-1:0]  child;
	logic              child_missing;
	logic              leaf_step;
	logic              bit_step;
	logic              done_step;
	logic              new_res;
	logic [SYM_W-1:0]  new_sym;
	logic              new_err;
	logic              dec_accept;
	logic              wr_accept;
	logic [CNT_W-1:0]  sat_count;

	// Emission toward the output registers.
	logic              emit_v;
	logic [SYM_W-1:0]  emit_sym;
	logic              emit_err;
	logic              emit_last;

	htwd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	assign busy       = (state_q != ST_IDLE);
	assign dec_accept = start && !busy && (req_type == REQ_DECODE);
	assign wr_accept  = start && !busy && (req_type == REQ_NODE_WRITE)
		&& (32'(node_index) < 32'(NODE_COUNT));
	assign sat_count  = (bit_count > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : bit_count;

	// The entry of the current node comes either from the root shadow register
	// (right after a symbol or an error) or from the RAM read issued last cycle.
	assign ent           = use_root_q ? root_q : node_entry_t'(ram_rdata);
	// A freshly reached child must be checked for a symbol before it is walked.
	assign is_leaf       = chk_q && (ent.sym != '0);
	assign cur_bit       = bits_q[BYTE_W-1];
	assign child         = cur_bit ? ent.right : ent.left;
	assign child_missing = (child == '0) || (32'(child) >= 32'(NODE_COUNT));

	assign leaf_step = (state_q == ST_WALK) && is_leaf;
	assign bit_step  = (state_q == ST_WALK) && !is_leaf && (left_q != '0);
	assign done_step = (state_q == ST_WALK) && !is_leaf && (left_q == '0);
	assign new_res   = leaf_step || (bit_step && child_missing);
	assign new_err   = !leaf_step;
	assign new_sym   = leaf_step ? ent.sym : '0;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (dec_accept) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (done_step) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// RAM control and result emission.
	always_comb begin
		ram_we    = wr_accept;
		ram_waddr = AW'(node_index);
		ram_wdata = {left_child, right_child, node_symbol};
		ram_raddr = pos_q;
		emit_v    = 1'b0;
		emit_sym  = pend_sym_q;
		emit_err  = pend_err_q;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = pos_q;
			end
			ST_WALK: begin
				ram_raddr = AW'(child);
				// A new result proves the pending one is not the last.
				emit_v    = new_res && pend_v_q;
			end
			ST_FLUSH: begin
				emit_v    = pend_v_q;
				emit_last = 1'b1;
			end
			default: begin
				emit_v = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			left_q       <= '0;
			use_root_q   <= 1'b0;
			chk_q        <= 1'b0;
			pend_v_q     <= 1'b0;
			res_strobe_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			res_strobe_q <= emit_v;
			if (dec_accept) begin
				left_q     <= sat_count;
				use_root_q <= 1'b0;
				chk_q      <= 1'b0;
			end
			if (leaf_step) begin
				pos_q      <= '0;
				use_root_q <= 1'b1;
				chk_q      <= 1'b0;
			end
			if (bit_step) begin
				left_q <= left_q - CNT_W'(1);
				if (child_missing) begin
					pos_q      <= '0;
					use_root_q <= 1'b1;
					chk_q      <= 1'b0;
				end else begin
					pos_q      <= AW'(child);
					use_root_q <= 1'b0;
					chk_q      <= 1'b1;
				end
			end
			if (done_step && fin_q) begin
				pos_q <= '0;
			end
			if (new_res) begin
				pend_v_q <= 1'b1;
			end else if (state_q == ST_FLUSH) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (dec_accept) begin
			bits_q <= data_byte;
			fin_q  <= final_byte;
		end else if (bit_step) begin
			bits_q <= {bits_q[BYTE_W-2:0], 1'b0};
		end
		if (wr_accept && (node_index == '0)) begin
			root_q <= {left_child, right_child, node_symbol};
		end
		if (new_res) begin
			pend_sym_q <= new_sym;
			pend_err_q <= new_err;
		end
		res_sym_q  <= emit_sym;
		res_err_q  <= emit_err;
		res_last_q <= emit_last;
	end

	assign result_strobe = res_strobe_q;
	assign symbol        = res_sym_q;
	assign walk_error    = res_err_q;
	assign last_of_run   = res_last_q;

endmodule

[sv/htwd_checker.sv]
// Port-level checker for the tree-walk decoder, bound to the top level.
// Depends on htwd_pkg.
module htwd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      req_type,
	input logic                      result_strobe,
	input logic [htwd_pkg::SYM_W-1:0] symbol,
	input logic                      walk_error,
	input logic                      last_of_run
);

	import htwd_pkg::*;

	// A decode item always occupies the block in the following cycle.
	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == REQ_DECODE) |=> busy)
		else $error("decode item did not raise busy");

	// A node write finishes at once and causes no result.
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == REQ_NODE_WRITE) |=> !busy && !result_strobe)
		else $error("node write caused busy or a result");

	// Every result comes out of a cycle in which the block was working.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without preceding work");

	// The last result of a byte coincides with the block becoming free.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_of_run |-> !busy)
		else $error("last result while still busy");

	// An error result carries no symbol.
	a_error_sym: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && walk_error |-> (symbol == '0))
		else $error("error result with nonzero symbol");

endmodule

bind huffman_tree_walk_decoder htwd_checker u_htwd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.req_type     (req_type),
	.result_strobe(result_strobe),
	.symbol       (symbol),
	.walk_error   (walk_error),
	.last_of_run  (last_of_run)
);

[tb/sv/tb_huffman_tree_walk_decoder.sv]
// Self-checking testbench for huffman_tree_walk_decoder: a directed table,
// then random code trees, coded streams and noise, checked by a shadow walk
// or by hand-written expectations. Depends on htwd_pkg and the decoder RTL.
module tb_huffman_tree_walk_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import htwd_pkg::*;

	localparam int NODES = NODE_COUNT_DEF;

	// One item on the command side. The typed fields let a directed row carry
	// an expectation written by hand: t_count results, all with the same
	// symbol and error flag, the last one marked as last of its byte.
	typedef struct {
		logic             req;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] lch;
		logic [IDX_W-1:0] rch;
		logic [SYM_W-1:0] nsym;
		logic [BYTE_W-1:0] data;
		logic [CNT_W-1:0] cnt;
		logic             fin;
		bit               typed;
		int               t_count;
		logic [SYM_W-1:0] t_sym;
		logic             t_err;
	} stim_t;

	typedef struct {
		logic [SYM_W-1:0] sym;
		logic             err;
		logic             last;
	} sym_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              req_type;
	logic [IDX_W-1:0]  node_index;
	logic [IDX_W-1:0]  left_child;
	logic [IDX_W-1:0]  right_child;
	logic [SYM_W-1:0]  node_symbol;
	logic [BYTE_W-1:0] data_byte;
	logic [CNT_W-1:0]  bit_count;
	logic              final_byte;
	logic              result_strobe;
	logic [SYM_W-1:0]  symbol;
	logic              walk_error;
	logic              last_of_run;

	// Shadow copy of the node table and of the walk position. Every entry that
	// the walk can ever read is written first; shadow_written tracks that, and
	// written_idx lists the entries that may safely be used as children.
	logic [IDX_W-1:0] shadow_left  [NODES];
	logic [IDX_W-1:0] shadow_right [NODES];
	logic [SYM_W-1:0] shadow_sym   [NODES];
	bit               shadow_written [NODES];
	int               written_idx[$];
	logic [IDX_W-1:0] walk_pos;

	sym_result_t expected_symbols[$];
	sym_result_t byte_results[$];
	bit          stream_bits[$];

	int idle_pct;
	int n_items;
	int n_writes;
	int n_decodes;
	int n_checked;
	int n_err_seen;
	int n_mismatch;

	huffman_tree_walk_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.node_index   (node_index),
		.left_child   (left_child),
		.right_child  (right_child),
		.node_symbol  (node_symbol),
		.data_byte    (data_byte),
		.bit_count    (bit_count),
		.final_byte   (final_byte),
		.result_strobe(result_strobe),
		.symbol       (symbol),
		.walk_error   (walk_error),
		.last_of_run  (last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A node write item. The decode fields are ignored by the block, so they
	// carry random values to keep those ports toggling.
	function automatic stim_t node_row(int idx, int l, int r, int s);
		stim_t st;
		st.req     = REQ_NODE_WRITE;
		st.idx     = IDX_W'(idx);
		st.lch     = IDX_W'(l);
		st.rch     = IDX_W'(r);
		st.nsym    = SYM_W'(s);
		st.data    = BYTE_W'($urandom);
		st.cnt     = CNT_W'($urandom);
		st.fin     = 1'($urandom);
		st.typed   = 1'b0;
		st.t_count = 0;
		st.t_sym   = '0;
		st.t_err   = 1'b0;
		return st;
	endfunction

	function automatic stim_t byte_row(int data, int cnt, bit fin);
		stim_t st;
		st.req     = REQ_DECODE;
		st.idx     = IDX_W'($urandom);
		st.lch     = IDX_W'($urandom);
		st.rch     = IDX_W'($urandom);
		st.nsym    = SYM_W'($urandom);
		st.data    = BYTE_W'(data);
		st.cnt     = CNT_W'(cnt);
		st.fin     = fin;
		st.typed   = 1'b0;
		st.t_count = 0;
		st.t_sym   = '0;
		st.t_err   = 1'b0;
		return st;
	endfunction

	function automatic stim_t typed_row(int data, int cnt, bit fin, int n, int s, bit e);
		stim_t st;
		st         = byte_row(data, cnt, fin);
		st.typed   = 1'b1;
		st.t_count = n;
		st.t_sym   = SYM_W'(s);
		st.t_err   = e;
		return st;
	endfunction

	// Applies one accepted item to the shadow state. For a decode byte the
	// results it causes are left in byte_results, in order.
	function automatic void walk_predict(stim_t st);
		int               nbits;
		logic [IDX_W-1:0] cur;
		logic [IDX_W-1:0] nxt;
		byte_results.delete();
		if (st.req == REQ_NODE_WRITE) begin
			if (st.idx < NODES) begin
				shadow_left[st.idx]  = st.lch;
				shadow_right[st.idx] = st.rch;
				shadow_sym[st.idx]   = st.nsym;
				if (!shadow_written[st.idx]) begin
					shadow_written[st.idx] = 1'b1;
					written_idx.push_back(int'(st.idx));
				end
			end
			return;
		end
		// Counts above eight are taken as eight.
		nbits = (st.cnt > MAX_BITS) ? MAX_BITS : st.cnt;
		for (int i = 0; i < nbits; i++) begin
			cur = walk_pos;
			nxt = st.data[BYTE_W-1-i] ? shadow_right[cur] : shadow_left[cur];
			if (nxt == 0 || nxt >= NODES) begin
				// Missing child: an error result, and the walk restarts at the root.
				byte_results.push_back('{sym: '0, err: 1'b1, last: 1'b0});
				walk_pos = '0;
			end else if (shadow_sym[nxt] != 0) begin
				byte_results.push_back('{sym: shadow_sym[nxt], err: 1'b0, last: 1'b0});
				walk_pos = '0;
			end else begin
				walk_pos = nxt;
			end
		end
		// A final byte always leaves the walk at the root, even with no bits.
		if (st.fin)
			walk_pos = '0;
		if (byte_results.size() > 0)
			byte_results[byte_results.size()-1].last = 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		n_mismatch++;
	endtask

	// Sends one item: an optional random gap with start low, then the item
	// held on the ports until an edge sees start high and busy low. The
	// expectations are queued at that same edge.
	task automatic issue_item(stim_t st);
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		req_type    <= st.req;
		node_index  <= st.idx;
		left_child  <= st.lch;
		right_child <= st.rch;
		node_symbol <= st.nsym;
		data_byte   <= st.data;
		bit_count   <= st.cnt;
		final_byte  <= st.fin;
		start       <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		n_items++;
		if (st.req == REQ_NODE_WRITE)
			n_writes++;
		else
			n_decodes++;
		walk_predict(st);
		if (st.typed) begin
			for (int k = 0; k < st.t_count; k++)
				expected_symbols.push_back('{sym: st.t_sym, err: st.t_err,
					last: (k == st.t_count - 1)});
		end else begin
			foreach (byte_results[k])
				expected_symbols.push_back(byte_results[k]);
		end
	endtask

	// A child for a node write. With any_value set, the node is a leaf that the
	// walk can never stand on, so its children are never read and may be any
	// index. Otherwise the child must be missing or an entry already written.
	function automatic int pick_child(bit any_value);
		if (any_value)
			return $urandom_range(0, NODES - 1);
		if (written_idx.size() == 0 || $urandom_range(0, 9) == 0)
			return 0;
		return written_idx[$urandom_range(0, written_idx.size() - 1)];
	endfunction

	// True when a node write may carry arbitrary children: a leaf that is
	// neither the root nor the node the walk currently stands on.
	function automatic bit loose_children(int idx, int s);
		return (s != 0) && (idx != 0) && (idx != walk_pos);
	endfunction

	task automatic put_node(int idx, int s, int l, int r);
		issue_item(node_row(idx, l, r, s));
	endtask

	// Builds a fresh code tree, Huffman style: random leaves first, then pairs
	// of subtrees joined under new internal nodes, the last join landing on
	// the root. Now and then one child of a join is cut off, so that coded
	// streams meet missing children only through noise or broken sequences.
	task automatic build_tree();
		int leaves;
		int node;
		int pos;
		int a;
		int b;
		int s;
		bit loose;
		int subtrees[$];
		bit taken [NODES];
		leaves = $urandom_range(2, 10);
		for (int k = 0; k < leaves; k++) begin
			do node = $urandom_range(1, NODES - 1); while (taken[node]);
			taken[node] = 1'b1;
			s = $urandom_range(1, 255);
			loose = loose_children(node, s);
			put_node(node, s, pick_child(loose), pick_child(loose));
			subtrees.push_back(node);
		end
		while (subtrees.size() > 1) begin
			pos = $urandom_range(0, subtrees.size() - 1);
			a = subtrees[pos];
			subtrees.delete(pos);
			pos = $urandom_range(0, subtrees.size() - 1);
			b = subtrees[pos];
			subtrees.delete(pos);
			if (subtrees.size() == 0) begin
				node = 0;
			end else begin
				do node = $urandom_range(1, NODES - 1); while (taken[node]);
				taken[node] = 1'b1;
			end
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1))
					a = 0;
				else
					b = 0;
			end
			put_node(node, 0, a, b);
			subtrees.push_back(node);
		end
	endtask

	// Appends the code of one reachable leaf, found by a random walk down the
	// shadow table. Noise may have bent the tree into a loop, so the length
	// is bounded.
	function automatic void append_code();
		int               len;
		bit               b;
		logic [IDX_W-1:0] cur;
		logic [IDX_W-1:0] nxt;
		cur = '0;
		len = 0;
		while (len < 24) begin
			if (shadow_left[cur] == 0 && shadow_right[cur] == 0)
				break;
			if (shadow_left[cur] == 0)
				b = 1'b1;
			else if (shadow_right[cur] == 0)
				b = 1'b0;
			else
				b = 1'($urandom_range(0, 1));
			stream_bits.push_back(b);
			nxt = b ? shadow_right[cur] : shadow_left[cur];
			if (shadow_sym[nxt] != 0)
				break;
			cur = nxt;
			len++;
		end
	endfunction

	// Sends a coded stream of whole codes, packed MSB first into bytes, the
	// last byte padded with random bits and marked final. A broken stream
	// loses its tail or has one bit flipped.
	task automatic send_stream(bit broken);
		int               nsyms;
		int               take;
		int               cnt;
		int               drop;
		logic [BYTE_W-1:0] data;
		// A stream has to start at the root: an empty final byte gets it there.
		if (walk_pos != 0)
			issue_item(byte_row($urandom, 0, 1'b1));
		stream_bits.delete();
		nsyms = $urandom_range(1, 12);
		repeat (nsyms)
			append_code();
		if (broken && stream_bits.size() > 1) begin
			if ($urandom_range(0, 1)) begin
				drop = $urandom_range(1,
					(stream_bits.size() - 1 < 3) ? stream_bits.size() - 1 : 3);
				repeat (drop)
					void'(stream_bits.pop_back());
			end else begin
				take = $urandom_range(0, stream_bits.size() - 1);
				stream_bits[take] = !stream_bits[take];
			end
		end
		while (stream_bits.size() > 0) begin
			take = (stream_bits.size() > MAX_BITS) ? MAX_BITS : stream_bits.size();
			data = BYTE_W'($urandom);
			for (int k = 0; k < take; k++)
				data[BYTE_W-1-k] = stream_bits.pop_front();
			cnt = take;
			// A full byte may also say so with a count above eight.
			if (take == MAX_BITS && $urandom_range(0, 5) == 0)
				cnt = $urandom_range(9, 15);
			issue_item(byte_row(data, cnt, stream_bits.size() == 0));
		end
	endtask

	// One random phase: rounds of a new tree followed by a handful of coded
	// streams, with noise writes and noise bytes mixed in.
	task automatic run_phase(int target);
		int first;
		int pick;
		int idx;
		int s;
		bit loose;
		first = n_items;
		while (n_items - first < target) begin
			build_tree();
			repeat ($urandom_range(4, 9)) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					idx = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, NODES - 1);
					s = $urandom_range(0, 1) ? $urandom_range(1, 255) : 0;
					loose = loose_children(idx, s);
					put_node(idx, s, pick_child(loose), pick_child(loose));
				end else if (pick < 24) begin
					issue_item(byte_row($urandom, $urandom_range(0, 15),
						$urandom_range(0, 3) == 0));
				end else begin
					send_stream(pick >= 88);
				end
			end
		end
	endtask

	// Results cannot be held off, so every strobe is checked at the edge
	// that ends its cycle against the oldest expectation.
	always @(posedge clk) begin
		sym_result_t want;
		if (arst_n === 1'b1 && result_strobe === 1'b1) begin
			if (walk_error === 1'b1)
				n_err_seen++;
			if (expected_symbols.size() == 0) begin
				report_mismatch($sformatf(
					"result with nothing expected: symbol %0h error %0b last %0b",
					symbol, walk_error, last_of_run));
			end else begin
				want = expected_symbols.pop_front();
				n_checked++;
				if (symbol !== want.sym)
					report_mismatch($sformatf("symbol %0h, expected %0h", symbol, want.sym));
				if (walk_error !== want.err)
					report_mismatch($sformatf("walk_error %0b, expected %0b", walk_error, want.err));
				if (last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %0b, expected %0b",
						last_of_run, want.last));
			end
		end
	end

	initial begin
		stim_t dir_rows[$];
		int    drain;
		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = REQ_NODE_WRITE;
		node_index  = '0;
		left_child  = '0;
		right_child = '0;
		node_symbol = '0;
		data_byte   = '0;
		bit_count   = '0;
		final_byte  = 1'b0;
		walk_pos    = '0;
		idle_pct    = 0;
		n_items     = 0;
		n_writes    = 0;
		n_decodes   = 0;
		n_checked   = 0;
		n_err_seen  = 0;
		n_mismatch  = 0;

		// Directed tree: the root goes left to node 1 and has no right child;
		// node 1 goes left to leaf 511 (symbol FF) and right to leaf 256 (01).
		dir_rows.push_back(node_row(511, 0, 511, 8'hFF));
		dir_rows.push_back(node_row(256, 9'h1FF, 9'h100, 8'h01));
		dir_rows.push_back(node_row(1, 511, 256, 0));
		dir_rows.push_back(node_row(0, 1, 0, 0));
		dir_rows.push_back(typed_row(8'h00, 8, 1'b0, 4, 8'hFF, 1'b0));
		// All ones from the root hit the missing right child eight times.
		dir_rows.push_back(typed_row(8'hFF, 8, 1'b0, 8, 0, 1'b1));
		dir_rows.push_back(typed_row(8'h55, 8, 1'b0, 4, 8'h01, 1'b0));
		// The largest count behaves as eight bits.
		dir_rows.push_back(typed_row(8'h00, 15, 1'b0, 4, 8'hFF, 1'b0));
		// A zero count decodes nothing.
		dir_rows.push_back(typed_row(8'hFF, 0, 1'b0, 0, 0, 1'b0));
		// A code that spans two bytes.
		dir_rows.push_back(typed_row(8'h00, 1, 1'b0, 0, 0, 1'b0));
		dir_rows.push_back(typed_row(8'h80, 1, 1'b0, 1, 8'h01, 1'b0));
		// A final byte with no bits still sends the walk back to the root.
		dir_rows.push_back(typed_row(8'h00, 1, 1'b0, 0, 0, 1'b0));
		dir_rows.push_back(typed_row(8'h7F, 0, 1'b1, 0, 0, 1'b0));
		dir_rows.push_back(typed_row(8'h80, 1, 1'b0, 1, 0, 1'b1));
		// A final byte that stops in mid-code.
		dir_rows.push_back(typed_row(8'h00, 1, 1'b1, 0, 0, 1'b0));
		dir_rows.push_back(typed_row(8'hC0, 2, 1'b0, 2, 0, 1'b1));
		// A node write in the middle of a code leaves the walk where it is.
		dir_rows.push_back(typed_row(8'h00, 1, 1'b0, 0, 0, 1'b0));
		dir_rows.push_back(node_row(300, 0, 0, 8'h80));
		dir_rows.push_back(typed_row(8'h80, 1, 1'b0, 1, 8'h01, 1'b0));
		// Symbol and error in one byte.
		dir_rows.push_back(byte_row(8'h20, 3, 1'b0));
		// Node 1 rewritten: left now leads to leaf 300, right is missing.
		dir_rows.push_back(node_row(1, 300, 0, 0));
		dir_rows.push_back(byte_row(8'h2A, 8, 1'b1));
		dir_rows.push_back(typed_row(8'h00, 4, 1'b1, 2, 8'h80, 1'b0));
		// A root with no children turns every bit into an error.
		dir_rows.push_back(node_row(0, 0, 0, 0));
		dir_rows.push_back(typed_row(8'hA5, 8, 1'b0, 8, 0, 1'b1));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			issue_item(dir_rows[i]);

		// Random part in three pacing regimes: light gaps, heavy gaps, none.
		idle_pct = 23;
		run_phase(100);
		idle_pct = 74;
		run_phase(100);
		idle_pct = 0;
		run_phase(100);

		@(negedge clk);
		start <= 1'b0;

		// Wait, within a bound, for the results still expected.
		drain = 0;
		while (expected_symbols.size() != 0 && drain < 200) begin
			@(posedge clk);
			drain++;
		end
		if (expected_symbols.size() != 0)
			report_mismatch($sformatf("%0d expected results never came",
				expected_symbols.size()));
		repeat (40) @(posedge clk);

		$display("Ran %0d items: %0d node writes and %0d decode bytes over several code trees.",
			n_items, n_writes, n_decodes);
		$display("Checked %0d results, %0d of them walk errors; %0d mismatches.",
			n_checked, n_err_seen, n_mismatch);
		if (n_mismatch == 0)
			$display("tb_huffman_tree_walk_decoder: done, clean");
		else
			$display("tb_huffman_tree_walk_decoder: done, errors");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("tb_huffman_tree_walk_decoder: done, errors");
		$finish;
	end

endmodule

[files.f]
sv/htwd_pkg.sv
sv/htwd_ram.sv
sv/huffman_tree_walk_decoder.sv
sv/htwd_checker.sv
tb/sv/tb_huffman_tree_walk_decoder.sv
